@@ design/rfc_pkg.sv @@
// Shared types and constants of the replay filter cache
package rfc_pkg;

  localparam int CACHE_DEPTH_DEF = 32;
  localparam int ID_W            = 32;
  localparam int STAMP_W         = 32;
  localparam int WINDOW_W        = 32;
  localparam int OPCODE_W        = 2;
  localparam int ENTRY_COUNT_W   = 6;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(30000);

  localparam logic [OPCODE_W-1:0] OP_CHECK = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_PURGE = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]    pkt_id;
    logic [STAMP_W-1:0] stamp;
    logic               live;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic sort;
    logic phase;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_SORT = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

endpackage

@@ design/rfc_req_if.sv @@
// Request channel of the replay filter cache
interface rfc_req_if import rfc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ID_W-1:0]     pkt_id;
  logic [STAMP_W-1:0]  packet_time;
  logic [STAMP_W-1:0]  now_time;

  modport source (output valid, opcode, pkt_id, packet_time, now_time, input ready);
  modport sink   (input valid, opcode, pkt_id, packet_time, now_time, output ready);
endinterface

@@ design/rfc_rsp_if.sv @@
// Response channel of the replay filter cache
interface rfc_rsp_if import rfc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic [ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, accepted, entry_count, input ready);
  modport sink   (input valid, accepted, entry_count, output ready);
endinterface

@@ design/rfc_cell.sv @@
// One table cell: rotates towards the head or swaps with a neighbour during compaction
module rfc_cell import rfc_pkg::*; #(
  parameter bit ODD      = 1'b0,
  parameter bit LOW_END  = 1'b0,
  parameter bit HIGH_END = 1'b0
) (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  entry_t    upper_i,
  input  entry_t    lower_i,
  output entry_t    entry_o
);

  entry_t entry_q, entry_d;
  logic   as_lower, as_upper, take_up, take_low;

  always_comb begin
    as_lower = (ODD == ctl_i.phase) && !HIGH_END;
    as_upper = (ODD != ctl_i.phase) && !LOW_END;
    take_up  = ctl_i.sort && as_lower && !entry_q.live && upper_i.live;
    take_low = ctl_i.sort && as_upper && !lower_i.live && entry_q.live;
    entry_d  = entry_q;
    if (ctl_i.shift || take_up) begin
      entry_d = upper_i;
    end else if (take_low) begin
      entry_d = lower_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ design/replay_filter_cache.sv @@
// Replay filter cache top level: control sequencer around a rotating row of cells
//
// The table is a ring of CACHE_DEPTH cells that rotates one place per cycle past a
// single head comparator, so every operation walks the whole table. A check, an
// append to a table with room, and an unused opcode make one rotation before the
// response. An add to a full table needs a second rotation: the first finds the
// oldest entry, the second replaces it. A purge makes one rotation that marks the
// entries still inside the window, then rounds of odd/even neighbour swaps move
// them to the front in their original order. One request is worked at a time;
// the next one is taken while the previous response waits in its output register.
// The window register is written through cfg_we_i/cfg_wdata_i; the user must do so
// only while the block is idle, as the block itself does not enforce it.
module replay_filter_cache import rfc_pkg::*; #(
  parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WINDOW_W-1:0] cfg_wdata_i,
  rfc_req_if.sink             req_i,
  rfc_rsp_if.source           rsp_o
);

  localparam int IW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CW = $clog2(CACHE_DEPTH + 1);

  state_e                   state_q, state_d;
  logic [IW-1:0]            cnt_q, cnt_d;
  logic                     pass2_q, pass2_d;
  logic [OPCODE_W-1:0]      op_q, op_d;
  logic [ID_W-1:0]          id_q, id_d;
  logic [STAMP_W-1:0]       now_q, now_d;
  logic                     win_ok_q, win_ok_d;
  logic                     hit_q, hit_d;
  logic [STAMP_W-1:0]       min_q, min_d;
  logic [IW-1:0]            victim_q, victim_d;
  logic [CW-1:0]            kept_q, kept_d;
  logic [CW-1:0]            count_q, count_d;
  logic                     acc_q, acc_d;
  logic [WINDOW_W-1:0]      window_q;
  logic                     rsp_valid_q, rsp_valid_d;
  logic                     rsp_acc_q, rsp_acc_d;
  logic [ENTRY_COUNT_W-1:0] rsp_count_q, rsp_count_d;

  entry_t                   cells [CACHE_DEPTH];
  entry_t                   head, feed, new_e;
  cell_ctl_t                ctl;
  logic                     last, full, in_use, hit_now, keep_now, req_fire;
  logic [CW-1:0]            cnt_ext;
  logic [STAMP_W-1:0]       diff, age;
  logic [CW+ENTRY_COUNT_W-1:0] count_wide;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  always_comb begin
    head     = cells[0];
    new_e    = '{pkt_id: id_q, stamp: now_q, live: 1'b1};
    cnt_ext  = CW'(cnt_q);
    last     = (cnt_q == IW'(CACHE_DEPTH - 1));
    full     = (count_q == CW'(CACHE_DEPTH));
    in_use   = (cnt_ext < count_q);
    hit_now  = in_use && (head.pkt_id == id_q);
    age      = now_q - head.stamp;
    keep_now = in_use && (age <= window_q);
    diff     = (req_i.packet_time > req_i.now_time) ? (req_i.packet_time - req_i.now_time)
                                                    : (req_i.now_time - req_i.packet_time);

    feed = head;
    case (op_q)
      OP_ADD: begin
        if (!full) begin
          if (cnt_ext == count_q) begin
            feed = new_e;
          end
        end else if (pass2_q && (cnt_q == victim_q)) begin
          feed = new_e;
        end
      end
      OP_PURGE: begin
        feed.live = keep_now;
      end
      default: begin
        feed = head;
      end
    endcase

    ctl.shift = (state_q == S_SCAN);
    ctl.sort  = (state_q == S_SORT);
    ctl.phase = cnt_q[0];
  end

  for (genvar k = 0; k < CACHE_DEPTH; k++) begin : g_cell
    rfc_cell #(
      .ODD      (bit'(k % 2)),
      .LOW_END  (k == 0),
      .HIGH_END (k == CACHE_DEPTH - 1)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .upper_i ((k == CACHE_DEPTH - 1) ? feed : cells[(k + 1) % CACHE_DEPTH]),
      .lower_i ((k == 0) ? feed : cells[(k + CACHE_DEPTH - 1) % CACHE_DEPTH]),
      .entry_o (cells[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pass2_d     = pass2_q;
    op_d        = op_q;
    id_d        = id_q;
    now_d       = now_q;
    win_ok_d    = win_ok_q;
    hit_d       = hit_q;
    min_d       = min_q;
    victim_d    = victim_q;
    kept_d      = kept_q;
    count_d     = count_q;
    acc_d       = acc_q;
    count_wide  = {{ENTRY_COUNT_W{1'b0}}, count_q};
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_acc_d   = rsp_acc_q;
    rsp_count_d = rsp_count_q;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          op_d     = req_i.opcode;
          id_d     = req_i.pkt_id;
          now_d    = req_i.now_time;
          win_ok_d = (diff <= window_q);
          hit_d    = 1'b0;
          kept_d   = '0;
          pass2_d  = 1'b0;
          cnt_d    = '0;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + IW'(1);
        hit_d = hit_q || hit_now;
        if (keep_now) begin
          kept_d = kept_q + CW'(1);
        end
        if (!pass2_q && ((cnt_q == '0) || (head.stamp < min_q))) begin
          min_d    = head.stamp;
          victim_d = cnt_q;
        end
        if (last) begin
          cnt_d = '0;
          acc_d = 1'b0;
          case (op_q)
            OP_CHECK: begin
              acc_d   = win_ok_q && !(hit_q || hit_now);
              state_d = S_DONE;
            end
            OP_ADD: begin
              if (!full) begin
                count_d = count_q + CW'(1);
                state_d = S_DONE;
              end else if (!pass2_q) begin
                pass2_d = 1'b1;
              end else begin
                state_d = S_DONE;
              end
            end
            OP_PURGE: begin
              count_d = kept_q + CW'(keep_now);
              state_d = S_SORT;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SORT: begin
        cnt_d = cnt_q + IW'(1);
        if (last) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_acc_d   = acc_q;
          rsp_count_d = count_wide[ENTRY_COUNT_W-1:0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pass2_q     <= 1'b0;
      count_q     <= '0;
      window_q    <= WINDOW_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pass2_q     <= pass2_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    id_q        <= id_d;
    now_q       <= now_d;
    win_ok_q    <= win_ok_d;
    hit_q       <= hit_d;
    min_q       <= min_d;
    victim_q    <= victim_d;
    kept_q      <= kept_d;
    acc_q       <= acc_d;
    rsp_acc_q   <= rsp_acc_d;
    rsp_count_q <= rsp_count_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.accepted    = rsp_acc_q;
  assign rsp_o.entry_count = rsp_count_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CACHE_DEPTH))
    else $error("entry count beyond table depth");

  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (cnt_q == '0))
    else $error("pass counter not parked while idle");

  a_check_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && op_q == OP_CHECK) |=> $stable(count_q))
    else $error("check changed the entry count");

  a_add_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && op_q == OP_ADD) |-> (count_q != '0))
    else $error("table empty after add");

endmodule
